// ===== src/sobol_pkg.sv =====
// Shared constants, codes and types of the Sobol sequence generator.
// Depends on nothing; sobol_if, the table builder and the top level import it.
`default_nettype none

package sobol_pkg;

    localparam int DEF_MAX_DEGREE    = 18;
    localparam int DEF_FRACTION_BITS = 32;

    // Fixed field widths
    localparam int IDX_W      = 32;
    localparam int POS_W      = 5;     // bit position inside an index word
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 5;
    localparam int INIT_W     = 18;
    localparam int DEG_W      = 5;
    localparam int INNER_W    = 17;
    localparam int BITS_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_INNER_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_USED       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_DIMENSION  = 2'd3;

    // Register reset values
    localparam logic [DEG_W-1:0]   RST_POLY_DEGREE     = 5'd1;
    localparam logic [INNER_W-1:0] RST_POLY_INNER_BITS = 17'd0;
    localparam logic [BITS_W-1:0]  RST_BITS_USED       = 6'd32;
    localparam logic               RST_UNIT_DIMENSION  = 1'b1;

    // Status from the table builder to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } build_stat_t;

endpackage

`default_nettype wire

// ===== src/sobol_if.sv =====
// Handshake channels of the Sobol generator: command items in, point items out.
// Depends on sobol_pkg.
`default_nettype none

interface sobol_in_if
    import sobol_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [INIT_W-1:0] init_value;

    modport source (output valid, output kind, output slot, output init_value, input ready);
    modport sink   (input valid, input kind, input slot, input init_value, output ready);
endinterface

interface sobol_out_if
    import sobol_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
();
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS-1:0] point;
    logic [IDX_W-1:0]         point_index;
    logic                     exhausted;

    modport source (output valid, output point, output point_index, output exhausted,
                    input ready);
    modport sink   (input valid, input point, input point_index, input exhausted,
                    output ready);
endinterface

`default_nettype wire

// ===== src/sobol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module sobol_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sobol_table_builder.sv =====
// Direction table builder: walks entries 1..L, writing each into the direction RAM
// from the initial numbers or the polynomial recurrence. Depends on sobol_pkg.
`default_nettype none

module sobol_table_builder
    import sobol_pkg::*;
#(
    parameter int  MAX_DEGREE    = DEF_MAX_DEGREE,
    parameter int  FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int IAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
    localparam int DAW = $clog2(FRACTION_BITS),
    localparam int VW  = $clog2(FRACTION_BITS + 1)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DEG_W-1:0]         poly_degree,
    input  wire logic [INNER_W-1:0]       poly_inner_bits,
    input  wire logic [BITS_W-1:0]        bits_used,
    input  wire logic                     unit_dimension,
    output logic                          init_re,
    output logic      [IAW-1:0]           init_raddr,
    input  wire logic [INIT_W-1:0]        init_rdata,
    output logic                          dir_we,
    output logic      [DAW-1:0]           dir_waddr,
    output logic      [FRACTION_BITS-1:0] dir_wdata,
    output logic                          dir_re,
    output logic      [DAW-1:0]           dir_raddr,
    input  wire logic [FRACTION_BITS-1:0] dir_rdata,
    output logic      [VW-1:0]            dir_count,
    output build_stat_t                   stat
);

    localparam int IW = $clog2(FRACTION_BITS + 2);
    localparam int SW = $clog2(MAX_DEGREE + 1);
    localparam int FB = FRACTION_BITS;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_ENTRY = 5'b00010,
        B_INIT  = 5'b00100,
        B_READ  = 5'b01000,
        B_LAST  = 5'b10000
    } bstate_t;

    bstate_t         st_reg, st_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [SW-1:0]   k_reg, k_next;
    logic [FB-1:0]   acc_reg, acc_next;
    logic            pend_reg, pend_next;
    logic [SW-1:0]   pend_k_reg, pend_k_next;

    logic [SW-1:0]        deg_s;
    logic [VW-1:0]        len;
    logic [IW-1:0]        shamt;
    logic [FB-1:0]        unit_val;
    logic [FB+INIT_W-1:0] init_wide;
    logic [SW-1:0]        abit_idx;
    logic [INNER_W-1:0]   a_sh;
    logic [FB-1:0]        term;
    logic                 done;

    // Clamp degree to 1..MAX_DEGREE and length to FRACTION_BITS
    always_comb
    begin
        if (poly_degree == '0)
        begin
            deg_s = SW'(1);
        end
        else if (int'(poly_degree) > MAX_DEGREE)
        begin
            deg_s = SW'(MAX_DEGREE);
        end
        else
        begin
            deg_s = SW'(poly_degree);
        end
        if (int'(bits_used) > FRACTION_BITS)
        begin
            len = VW'(FRACTION_BITS);
        end
        else
        begin
            len = VW'(bits_used);
        end
    end

    assign shamt     = IW'(FRACTION_BITS) - i_reg;
    assign unit_val  = {{(FB-1){1'b0}}, 1'b1} << shamt;
    assign init_wide = (FB + INIT_W)'(init_rdata) << shamt;

    // Contribution of the entry read back for offset pend_k: the degree tap
    // also folds in its own right shift, the others follow the coefficients.
    assign abit_idx = deg_s - pend_k_reg - SW'(1);
    assign a_sh     = poly_inner_bits >> abit_idx;

    always_comb
    begin
        if (pend_k_reg == deg_s)
        begin
            term = dir_rdata ^ (dir_rdata >> deg_s);
        end
        else if (a_sh[0])
        begin
            term = dir_rdata;
        end
        else
        begin
            term = '0;
        end
    end

    assign init_raddr = IAW'(i_reg - IW'(1));
    assign dir_waddr  = DAW'(i_reg - IW'(1));
    assign dir_raddr  = DAW'(i_reg - IW'(k_reg) - IW'(1));
    assign dir_count  = len;
    assign stat.busy  = (st_reg != B_IDLE);
    assign stat.done  = done;

    always_comb
    begin
        st_next     = st_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        pend_k_next = pend_k_reg;
        init_re     = 1'b0;
        dir_we      = 1'b0;
        dir_wdata   = '0;
        dir_re      = 1'b0;
        done        = 1'b0;
        unique case (st_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    i_next  = IW'(1);
                    st_next = B_ENTRY;
                end
            end
            B_ENTRY:
            begin
                if (int'(i_reg) > int'(len))
                begin
                    done    = 1'b1;
                    st_next = B_IDLE;
                end
                else if (unit_dimension)
                begin
                    dir_we    = 1'b1;
                    dir_wdata = unit_val;
                    i_next    = i_reg + IW'(1);
                end
                else if (int'(i_reg) <= int'(deg_s))
                begin
                    init_re = 1'b1;
                    st_next = B_INIT;
                end
                else
                begin
                    k_next    = deg_s;
                    acc_next  = '0;
                    pend_next = 1'b0;
                    st_next   = B_READ;
                end
            end
            B_INIT:
            begin
                dir_we    = 1'b1;
                dir_wdata = init_wide[FB-1:0];
                i_next    = i_reg + IW'(1);
                st_next   = B_ENTRY;
            end
            B_READ:
            begin
                // one earlier entry per cycle, oldest (offset = degree) first
                dir_re = 1'b1;
                if (pend_reg)
                begin
                    acc_next = acc_reg ^ term;
                end
                pend_next   = 1'b1;
                pend_k_next = k_reg;
                if (k_reg == SW'(1))
                begin
                    st_next = B_LAST;
                end
                else
                begin
                    k_next = k_reg - SW'(1);
                end
            end
            B_LAST:
            begin
                dir_we    = 1'b1;
                dir_wdata = acc_reg ^ term;
                pend_next = 1'b0;
                i_next    = i_reg + IW'(1);
                st_next   = B_ENTRY;
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_IDLE;
            pend_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        pend_k_reg <= pend_k_next;
    end

endmodule

`default_nettype wire

// ===== src/sobol_sequence_generator_top.sv =====
// Top level of the Sobol sequence generator: command decode, point update, result
// register. Depends on sobol_pkg, sobol_if, sobol_ram, sobol_table_builder.
`default_nettype none

// One dimension of a Sobol sequence in Gray-code order. Load items (kind 0) write an
// initial direction number into the init RAM. A restart item (kind 1) builds the
// direction RAM from the registers and loaded numbers, then emits point 0 at index 0;
// the build walks entries 1..L, L = min(bits_used, FRACTION_BITS), one at a time
// through the single read port of the direction RAM: the unit dimension writes each
// entry directly, otherwise entries up to the degree s come from the init RAM and
// each entry beyond it is formed from its s earlier entries, read back one by one.
// A next item (kind 2) runs index decode with the direction RAM read, XOR into the
// point, then the result register. When no direction number exists for the next
// index the held point and index come back with exhausted set. The result step waits
// while the previous item still sits unaccepted in the output register, and no new
// item is taken until it moves on. Register writes take effect at the next restart;
// a write during a build also reaches that build. No clearing pass after reset;
// loads must cover slots 1..s before a restart of a dimension other than the unit.
module sobol_sequence_generator_top
    import sobol_pkg::*;
#(
    parameter int MAX_DEGREE    = DEF_MAX_DEGREE,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    sobol_in_if.sink                   cmd,
    sobol_out_if.source                result
);

    localparam int IAW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DAW = $clog2(FRACTION_BITS);
    localparam int VW  = $clog2(FRACTION_BITS + 1);
    localparam int FB  = FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_STEP  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // Configuration registers
    logic [DEG_W-1:0]   poly_degree_reg;
    logic [INNER_W-1:0] poly_inner_bits_reg;
    logic [BITS_W-1:0]  bits_used_reg;
    logic               unit_dimension_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg     <= RST_POLY_DEGREE;
            poly_inner_bits_reg <= RST_POLY_INNER_BITS;
            bits_used_reg       <= RST_BITS_USED;
            unit_dimension_reg  <= RST_UNIT_DIMENSION;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLY_DEGREE:     poly_degree_reg     <= cfg_data[DEG_W-1:0];
                REG_POLY_INNER_BITS: poly_inner_bits_reg <= cfg_data[INNER_W-1:0];
                REG_BITS_USED:       bits_used_reg       <= cfg_data[BITS_W-1:0];
                REG_UNIT_DIMENSION:  unit_dimension_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    state_t            state_reg, state_next;
    logic [FB-1:0]     point_reg, point_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [VW-1:0]     valid_dirs_reg, valid_dirs_next;
    logic              exh_reg, exh_next;
    logic              out_valid_reg, out_valid_next;
    logic [FB-1:0]     out_point_reg, out_point_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic              out_exh_reg, out_exh_next;

    logic              accept;
    logic              can_emit;
    logic              load_ok;
    logic [IDX_W-1:0]  zero_hot;
    logic [POS_W-1:0]  zero_pos;
    logic              no_dir;

    // Init RAM and direction RAM ports
    logic              init_we;
    logic [IAW-1:0]    init_waddr;
    logic              init_re;
    logic [IAW-1:0]    init_raddr;
    logic [INIT_W-1:0] init_rdata;
    logic              dir_we;
    logic [DAW-1:0]    dir_waddr;
    logic [FB-1:0]     dir_wdata;
    logic              dir_re;
    logic [DAW-1:0]    dir_raddr;
    logic [FB-1:0]     dir_rdata;
    logic              b_dir_re;
    logic [DAW-1:0]    b_dir_raddr;
    logic [VW-1:0]     b_count;
    logic              b_start;
    build_stat_t       bstat;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid & cmd.ready;
    assign can_emit  = !out_valid_reg || result.ready;
    assign load_ok   = (cmd.slot != '0) && (int'(cmd.slot) <= MAX_DEGREE);

    // Lowest clear bit of the index selects the direction number (trailing ones + 1)
    assign zero_hot = ~index_reg & (index_reg + IDX_W'(1));

    always_comb
    begin
        zero_pos = '0;
        for (int j = 0; j < IDX_W; j++)
        begin
            if (zero_hot[j])
            begin
                zero_pos = zero_pos | POS_W'(j);
            end
        end
    end

    assign no_dir = (zero_hot == '0) || (int'(zero_pos) >= int'(valid_dirs_reg));

    assign init_we    = accept && (cmd.kind == KIND_LOAD) && load_ok;
    assign init_waddr = IAW'(cmd.slot - SLOT_W'(1));
    assign b_start    = accept && (cmd.kind == KIND_RESTART);

    // Builder owns the direction read port during a build, the stepper otherwise
    assign dir_re    = (state_reg == ST_BUILD) ? b_dir_re
                     : (accept && (cmd.kind == KIND_NEXT) && !no_dir);
    assign dir_raddr = (state_reg == ST_BUILD) ? b_dir_raddr : DAW'(zero_pos);

    sobol_ram #(
        .WIDTH (INIT_W),
        .DEPTH (MAX_DEGREE)
    ) u_init_ram (
        .clk   (clk),
        .we    (init_we),
        .waddr (init_waddr),
        .wdata (cmd.init_value),
        .re    (init_re),
        .raddr (init_raddr),
        .rdata (init_rdata)
    );

    sobol_ram #(
        .WIDTH (FB),
        .DEPTH (FRACTION_BITS)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    sobol_table_builder #(
        .MAX_DEGREE    (MAX_DEGREE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_builder (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (b_start),
        .poly_degree     (poly_degree_reg),
        .poly_inner_bits (poly_inner_bits_reg),
        .bits_used       (bits_used_reg),
        .unit_dimension  (unit_dimension_reg),
        .init_re         (init_re),
        .init_raddr      (init_raddr),
        .init_rdata      (init_rdata),
        .dir_we          (dir_we),
        .dir_waddr       (dir_waddr),
        .dir_wdata       (dir_wdata),
        .dir_re          (b_dir_re),
        .dir_raddr       (b_dir_raddr),
        .dir_rdata       (dir_rdata),
        .dir_count       (b_count),
        .stat            (bstat)
    );

    always_comb
    begin
        state_next      = state_reg;
        point_next      = point_reg;
        index_next      = index_reg;
        valid_dirs_next = valid_dirs_reg;
        exh_next        = exh_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_point_next  = out_point_reg;
        out_index_next  = out_index_reg;
        out_exh_next    = out_exh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.kind)
                        KIND_RESTART:
                        begin
                            state_next = ST_BUILD;
                        end
                        KIND_NEXT:
                        begin
                            exh_next   = no_dir;
                            state_next = no_dir ? ST_EMIT : ST_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUILD:
            begin
                if (bstat.done)
                begin
                    valid_dirs_next = b_count;
                    point_next      = '0;
                    index_next      = '0;
                    exh_next        = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_STEP:
            begin
                point_next = point_reg ^ dir_rdata;
                index_next = index_reg + IDX_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_point_next = point_reg;
                    out_index_next = index_reg;
                    out_exh_next   = exh_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            point_reg      <= '0;
            index_reg      <= '0;
            valid_dirs_reg <= '0;
            exh_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            point_reg      <= point_next;
            index_reg      <= index_next;
            valid_dirs_reg <= valid_dirs_next;
            exh_reg        <= exh_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_point_reg <= out_point_next;
        out_index_reg <= out_index_next;
        out_exh_reg   <= out_exh_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.point       = out_point_reg;
    assign result.point_index = out_index_reg;
    assign result.exhausted   = out_exh_reg;

    // The builder runs only while the top level waits for it
    a_build_owned: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.busy |-> state_reg == ST_BUILD)
        else $error("table builder busy outside build state");

    // A point update advances the index by exactly one
    a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |=> index_reg == $past(index_reg) + IDX_W'(1))
        else $error("index did not advance by one on a point update");

    // The count of built direction numbers never exceeds the table depth
    a_dir_count: assert property (@(posedge clk) disable iff (!rst_n)
        int'(valid_dirs_reg) <= FRACTION_BITS)
        else $error("direction count beyond table depth");

endmodule

`default_nettype wire
